// ===== src/mf3_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; used by mf3_median and median_filter_3x3.
package mf3_pkg;

  localparam int PIX_W         = 8;
  localparam int IMG_WIDTH_W   = 11;
  localparam int IMG_HEIGHT_W  = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MIN_DIM       = 3;

  localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  typedef logic [PIX_W-1:0] pix_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // One window column, sorted
  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } col_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sorts three pixels into lo, mid and hi with the min, max and median helpers
  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t res;
    res.lo  = min2(min2(a, b), c);
    res.hi  = max2(max2(a, b), c);
    res.mid = med3(a, b, c);
    return res;
  endfunction

endpackage

// ===== src/mf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the filter's line stores.
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mf3_median.sv =====
// Median of a 3x3 window held as three column-sorted columns.
// Depends on mf3_pkg (col_t, min2/max2/med3).
module mf3_median (
  input  mf3_pkg::col_t [2:0] win,
  output mf3_pkg::pix_t       med
);
  import mf3_pkg::*;

  pix_t low_max;
  pix_t mid_med;
  pix_t high_min;

  // Largest of the column minima, median of the medians, smallest of maxima
  assign low_max  = max2(max2(win[0].lo, win[1].lo), win[2].lo);
  assign mid_med  = med3(win[0].mid, win[1].mid, win[2].mid);
  assign high_min = min2(min2(win[0].hi, win[1].hi), win[2].hi);

  assign med = med3(low_max, mid_med, high_min);

endmodule

// ===== src/median_filter_3x3.sv =====
// 3x3 median filter over an 8-bit raster pixel stream.
// Depends on mf3_pkg, mf3_ram and mf3_median.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_stall/pixel_in; a transfer
//   happens when in_valid is high and in_stall low. Results leave on
//   out_valid/out_stall with pixel_value, out_row, out_column, frame_last.
//   Interior pixels leave as the median of their 3x3 neighborhood, border
//   pixels leave unchanged. Pixel (r,x) releases (r-1,x-1); at a row end
//   it also releases (r-1,x); on the last row it also releases itself.
//   image_width (index 0) and image_height (index 1) are written on the
//   cfg channel (cfg_ready is always high). The user must write them only
//   while the filter is idle; the block itself does not enforce this.
// Path: each pixel goes from stage 1 to stage 2, then to the output group.
// Throughput: one pixel per cycle while each pixel releases at most one
//   result and out_stall is low. Row-end pixels after row 0 and last-row
//   pixels after column 0 release two or three results and hold the input
//   while those drain, since the output port carries one result per cycle.
// Reset: counters return to row 0, column 0, the pipeline empties, and the
//   registers return to 640 x 480. Line store contents are kept.
// Output stall: results wait in a three-entry output register; the stall
//   backs up through the two pipeline stages to in_stall.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // pixel input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mf3_pkg::pix_t                        pixel_in,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mf3_pkg::pix_t                        pixel_value,
  output logic [mf3_pkg::IMG_HEIGHT_W-1:0]     out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_column,
  output logic                                 frame_last,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mf3_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mf3_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > IMG_WIDTH_W) ? WW : IMG_WIDTH_W;
  localparam int RW  = IMG_HEIGHT_W;

  // Per-pixel bookkeeping carried down the pipeline
  typedef struct packed {
    pix_t          pix;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic          row_end;
    logic          emit_prev;   // release (r-1, x-1)
    logic          emit_end;    // release (r-1, x) at row end
    logic          emit_self;   // release (r, x) on the last row
    logic          border;      // (r-1, x-1) lies on the border
  } meta_t;

  typedef struct packed {
    pix_t          pix;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic          last;
  } res_t;

  // Configuration registers
  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;

  // Position counters
  logic [RW-1:0] row_counter;
  logic [CW-1:0] column_counter;

  // Pipeline registers
  logic  s1_valid;
  meta_t s1_meta;
  logic  s2_valid;
  meta_t s2_meta;
  pix_t  s2_above;

  // Window: sorted columns plus raw middle-row values of columns 1 and 2
  col_t [2:0] win_sorted;
  pix_t       win_mid1;
  pix_t       win_mid2;

  // Output group
  res_t       grp [3];
  logic [1:0] grp_cnt;

  // Line store read data
  pix_t above_rd;
  pix_t two_above_rd;

  logic          accept;
  logic          s1_take;
  logic          s1_move;
  logic          s2_take;
  logic          grp_free;
  logic          grp_load;
  logic          pop;
  logic [EW-1:0] width_use;
  logic [EW-1:0] col_ext;
  logic [RW-1:0] height_use;
  logic          row_end;
  logic          row_last;
  meta_t         meta_next;
  pix_t          median;
  pix_t          prev_value;
  res_t          res_prev;
  res_t          res_end;
  res_t          res_self;
  logic [1:0]    res_cnt;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Limits in use: width held within 3..MAX_WIDTH, height at least 3
  always_comb begin
    if (EW'(image_width) < EW'(MIN_DIM)) begin
      width_use = EW'(MIN_DIM);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      width_use = EW'(MAX_WIDTH);
    end else begin
      width_use = EW'(image_width);
    end
    height_use = (image_height < RW'(MIN_DIM)) ? RW'(MIN_DIM) : image_height;
  end

  assign col_ext  = EW'(column_counter);
  assign row_end  = col_ext >= (width_use - EW'(1));
  assign row_last = row_counter >= (height_use - RW'(1));

  // Flow control: each stage moves when the one after it is free
  assign pop      = out_valid && !out_stall;
  assign grp_free = (grp_cnt == 2'd0) || ((grp_cnt == 2'd1) && pop);
  assign grp_load = s2_valid && grp_free;
  assign s2_take  = !s2_valid || grp_free;
  assign s1_move  = s1_valid && s2_take;
  assign s1_take  = !s1_valid || s2_take;
  assign accept   = in_valid && s1_take;
  assign in_stall = !s1_take;

  // Bookkeeping for the incoming pixel
  always_comb begin
    meta_next.pix       = pixel_in;
    meta_next.row       = row_counter;
    meta_next.col       = column_counter;
    meta_next.row_end   = row_end;
    meta_next.emit_prev = (row_counter != '0) && (column_counter != '0);
    meta_next.emit_end  = row_end && (row_counter != '0);
    meta_next.emit_self = row_last;
    meta_next.border    = (row_counter == RW'(1)) || (row_counter >= height_use) ||
                          (column_counter == CW'(1)) || (col_ext >= width_use);
  end

  // Row and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_counter <= '0;
        row_counter    <= row_last ? '0 : row_counter + RW'(1);
      end else begin
        column_counter <= column_counter + CW'(1);
      end
    end
  end

  // Line stores: read on transfer, write back when the pixel leaves stage 1
  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_above (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_meta.col),
    .wr_data (s1_meta.pix),
    .rd_en   (accept),
    .rd_addr (column_counter),
    .rd_data (above_rd)
  );

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_two_above (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_meta.col),
    .wr_data (above_rd),
    .rd_en   (accept),
    .rd_addr (column_counter),
    .rd_data (two_above_rd)
  );

  // Stage 1: waits for the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_next;
    end
  end

  // Stage 2: window shifts in the new column, sorted on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (grp_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_meta       <= s1_meta;
      s2_above      <= above_rd;
      win_sorted[0] <= win_sorted[1];
      win_sorted[1] <= win_sorted[2];
      win_sorted[2] <= sort3(two_above_rd, above_rd, s1_meta.pix);
      win_mid1      <= win_mid2;
      win_mid2      <= above_rd;
    end
  end

  mf3_median u_median (
    .win (win_sorted),
    .med (median)
  );

  // Results released by the pixel in stage 2
  always_comb begin
    prev_value = s2_meta.border ? win_mid1 : median;

    res_prev.pix  = prev_value;
    res_prev.row  = s2_meta.row - RW'(1);
    res_prev.col  = s2_meta.col - CW'(1);
    res_prev.last = 1'b0;

    res_end.pix   = s2_above;
    res_end.row   = s2_meta.row - RW'(1);
    res_end.col   = s2_meta.col;
    res_end.last  = 1'b0;

    res_self.pix  = s2_meta.pix;
    res_self.row  = s2_meta.row;
    res_self.col  = s2_meta.col;
    res_self.last = s2_meta.row_end;

    res_cnt = 2'(s2_meta.emit_prev) + 2'(s2_meta.emit_end) + 2'(s2_meta.emit_self);
  end

  // Output group: loaded packed from slot 0, drained one transfer per cycle while out_stall is low
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_cnt <= 2'd0;
    end else if (grp_load) begin
      grp_cnt <= res_cnt;
    end else if (pop) begin
      grp_cnt <= grp_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      if (s2_meta.emit_prev) begin
        grp[0] <= res_prev;
      end else if (s2_meta.emit_end) begin
        grp[0] <= res_end;
      end else begin
        grp[0] <= res_self;
      end
      grp[1] <= (s2_meta.emit_prev && s2_meta.emit_end) ? res_end : res_self;
      grp[2] <= res_self;
    end else if (pop) begin
      grp[0] <= grp[1];
      grp[1] <= grp[2];
    end
  end

  assign out_valid   = grp_cnt != 2'd0;
  assign pixel_value = grp[0].pix;
  assign out_row     = grp[0].row;
  assign out_column  = grp[0].col;
  assign frame_last  = grp[0].last;

endmodule
